// ===== design/counting_semaphore_resource_manager_top_assert.svh =====
// Assertion macros for the semaphore manager checker.
`ifndef COUNTING_SEMAPHORE_RESOURCE_MANAGER_TOP_ASSERT_SVH
`define COUNTING_SEMAPHORE_RESOURCE_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CSRM_ASSERT_NOW(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("csrm check failed");

// Next-cycle implication, disabled in reset.
`define CSRM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("csrm check failed");

// Next-cycle implication, also checked in reset.
`define CSRM_ASSERT_ALWAYS_NEXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("csrm check failed");

`endif

// ===== design/csrm_pkg.sv =====
// ----------------------------------------------------------------------------
// csrm_pkg
// Constants, codes and types shared by the semaphore manager files.
// ----------------------------------------------------------------------------
package csrm_pkg;

  localparam int NUM_RESOURCES = 4;
  localparam int WAIT_DEPTH    = 16;
  localparam int GRANT_ENTRIES = 32;

  localparam int PID_W   = 8;
  localparam int RES_W   = 2;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NUM_CFG    = 4;
  localparam int COUNT_MAX  = 255;

  localparam int WPTR_W  = $clog2(WAIT_DEPTH);
  localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
  localparam int FADDR_W = $clog2(NUM_RESOURCES * WAIT_DEPTH);
  localparam int GADDR_W = $clog2(GRANT_ENTRIES);
  localparam int GIDX_W  = $clog2(GRANT_ENTRIES + 1);

  localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCKED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREED      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WOKE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUEUE_FULL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TABLE_FULL = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE       = 3'd6;

  typedef logic signed [CNT_W-1:0] counter_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [RES_W-1:0] res;
  } grant_t;

endpackage

// ===== design/csrm_if.sv =====
// ----------------------------------------------------------------------------
// csrm channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface csrm_in_if;
  logic                       valid;
  logic                       ready;
  logic [csrm_pkg::CMD_W-1:0] command;
  logic [csrm_pkg::PID_W-1:0] pid;
  logic [csrm_pkg::RES_W-1:0] resource;
  modport source (output valid, command, pid, resource, input ready);
  modport sink   (input valid, command, pid, resource, output ready);
endinterface

interface csrm_out_if;
  logic                        valid;
  logic                        ready;
  logic [csrm_pkg::KIND_W-1:0] kind;
  logic [csrm_pkg::PID_W-1:0]  woken_pid;
  logic [csrm_pkg::RES_W-1:0]  resource_out;
  logic                        last;
  modport source (output valid, kind, woken_pid, resource_out, last, input ready);
  modport sink   (input valid, kind, woken_pid, resource_out, last, output ready);
endinterface

interface csrm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csrm_pkg::CFG_IDX_W-1:0]  index;
  logic [csrm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/counting_semaphore_resource_manager_top.sv =====
// Acquire: the result is registered in the emit state that follows the input transfer.
// Release one: table scan, a shift pass when a grant is removed, counter step,
// a wake state when a waiter is woken, then emit. Release all: a table sweep,
// then per freed grant a counter step (and a wake) and an emitted result, and a
// closing done result; the table holds 32 entries. Output stalls hold the emit state.
// One item at a time. Synchronous active-low reset loads every semaphore counter with 1.
// ----------------------------------------------------------------------------
// counting_semaphore_resource_manager_top
// Semaphore bank with per-resource wait FIFOs and an ordered grant table,
// both held in synchronous memories.
// ----------------------------------------------------------------------------
module counting_semaphore_resource_manager_top (
  input logic       clk,
  input logic       rst_n,
  csrm_in_if.sink   in_if,
  csrm_out_if.source out_if,
  csrm_cfg_if.sink  cfg_if
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN1 = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_SCANA = 3'd3;
  localparam logic [2:0] ST_INC   = 3'd4;
  localparam logic [2:0] ST_WAKE  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam int NR = csrm_pkg::NUM_RESOURCES;
  localparam int GW = csrm_pkg::GIDX_W;

  // memories
  csrm_pkg::grant_t              gmem [csrm_pkg::GRANT_ENTRIES];
  logic [csrm_pkg::PID_W-1:0]    fmem [NR * csrm_pkg::WAIT_DEPTH];
  csrm_pkg::grant_t              g_rdata_r;
  logic [csrm_pkg::PID_W-1:0]    f_rdata_r;

  logic                          g_we, g_re, f_we, f_re;
  logic [csrm_pkg::GADDR_W-1:0]  g_waddr, g_raddr;
  csrm_pkg::grant_t              g_wdata;
  logic [csrm_pkg::FADDR_W-1:0]  f_waddr, f_raddr;
  logic [csrm_pkg::PID_W-1:0]    f_wdata;

  // state
  logic [2:0]                    state_r;
  csrm_pkg::counter_t            cnt_r   [NR];
  logic [csrm_pkg::WPTR_W-1:0]   head_r  [NR];
  logic [csrm_pkg::WPTR_W-1:0]   tail_r  [NR];
  logic [csrm_pkg::WCNT_W-1:0]   wcnt_r  [NR];
  logic [GW-1:0]                 used_r, idx_r, p_idx_r, keep_r, nf_r, fi_r;
  logic                          p_v_r;
  logic [csrm_pkg::RES_W-1:0]    freed_r [csrm_pkg::GRANT_ENTRIES];
  logic [csrm_pkg::CMD_W-1:0]    cmd_r;
  logic [csrm_pkg::PID_W-1:0]    pid_r;
  logic [csrm_pkg::RES_W-1:0]    res_r;
  logic [csrm_pkg::KIND_W-1:0]   kind_r;
  logic [csrm_pkg::PID_W-1:0]    woken_r;
  logic                          last_r;
  logic                          out_valid_r;
  logic [csrm_pkg::KIND_W-1:0]   out_kind_r;
  logic [csrm_pkg::PID_W-1:0]    out_woken_r;
  logic [csrm_pkg::RES_W-1:0]    out_res_r;
  logic                          out_last_r;

  logic                          in_fire, issue, scan_done, table_full, res_ok;
  logic [csrm_pkg::RES_W-1:0]    inc_res;
  logic                          g_match;

  function automatic logic [csrm_pkg::FADDR_W-1:0] faddr(
    input logic [csrm_pkg::RES_W-1:0]  r,
    input logic [csrm_pkg::WPTR_W-1:0] p
  );
    faddr = csrm_pkg::FADDR_W'(32'(r) * csrm_pkg::WAIT_DEPTH + 32'(p));
  endfunction

  function automatic logic [csrm_pkg::WPTR_W-1:0] wrap_inc(
    input logic [csrm_pkg::WPTR_W-1:0] p
  );
    if (32'(p) == csrm_pkg::WAIT_DEPTH - 1) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = p + 1'b1;
    end
  endfunction

  function automatic csrm_pkg::counter_t sat_inc(input csrm_pkg::counter_t c);
    if (c < csrm_pkg::CNT_W'(csrm_pkg::COUNT_MAX)) begin
      sat_inc = c + csrm_pkg::counter_t'(1);
    end else begin
      sat_inc = c;
    end
  endfunction

  assign in_if.ready      = (state_r == ST_IDLE);
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.woken_pid = out_woken_r;
  assign out_if.resource_out = out_res_r;
  assign out_if.last      = out_last_r;

  assign in_fire    = in_if.valid && in_if.ready;
  assign issue      = (idx_r < used_r);
  assign scan_done  = !issue && !p_v_r;
  assign table_full = (32'(used_r) >= csrm_pkg::GRANT_ENTRIES);
  assign res_ok     = (32'(in_if.resource) < NR);
  assign g_match    = (g_rdata_r.pid == pid_r) && (g_rdata_r.res == res_r);
  assign inc_res    = (cmd_r == csrm_pkg::CMD_RELEASE_ALL) ?
                      freed_r[fi_r[csrm_pkg::GADDR_W-1:0]] : res_r;

  // memory port muxes
  always_comb begin
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    g_re    = 1'b0;
    g_raddr = idx_r[csrm_pkg::GADDR_W-1:0];
    f_we    = 1'b0;
    f_waddr = faddr(in_if.resource, tail_r[in_if.resource]);
    f_wdata = in_if.pid;
    f_re    = 1'b0;
    f_raddr = faddr(inc_res, head_r[inc_res]);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && res_ok && in_if.command == csrm_pkg::CMD_ACQUIRE) begin
          if (cnt_r[in_if.resource] >= 1) begin
            g_we    = !table_full;
            g_waddr = used_r[csrm_pkg::GADDR_W-1:0];
            g_wdata = '{pid: in_if.pid, res: in_if.resource};
          end else begin
            f_we = (32'(wcnt_r[in_if.resource]) < csrm_pkg::WAIT_DEPTH);
          end
        end
      end
      ST_SCAN1: g_re = issue;
      ST_SHIFT: begin
        g_re    = issue;
        g_we    = p_v_r;
        g_waddr = csrm_pkg::GADDR_W'(p_idx_r - 1'b1);
        g_wdata = g_rdata_r;
      end
      ST_SCANA: begin
        g_re    = issue;
        g_we    = p_v_r && (g_rdata_r.pid != pid_r);
        g_waddr = keep_r[csrm_pkg::GADDR_W-1:0];
        g_wdata = g_rdata_r;
      end
      ST_INC: f_re = (cnt_r[inc_res] < 0) && (wcnt_r[inc_res] != '0);
      ST_WAKE: begin
        g_we    = !table_full;
        g_waddr = used_r[csrm_pkg::GADDR_W-1:0];
        g_wdata = '{pid: f_rdata_r, res: res_r};
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      g_rdata_r <= gmem[g_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      f_rdata_r <= fmem[f_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      p_idx_r     <= '0;
      p_v_r       <= 1'b0;
      keep_r      <= '0;
      nf_r        <= '0;
      fi_r        <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NR; r++) begin
        cnt_r[r]  <= csrm_pkg::CNT_W'(1);
        head_r[r] <= '0;
        tail_r[r] <= '0;
        wcnt_r[r] <= '0;
      end
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      // register write reloads the counter and empties the wait FIFO
      if (cfg_if.valid && cfg_if.ready && 32'(cfg_if.index) < NR) begin
        cnt_r[cfg_if.index]  <= csrm_pkg::counter_t'({1'b0, cfg_if.data});
        head_r[cfg_if.index] <= '0;
        tail_r[cfg_if.index] <= '0;
        wcnt_r[cfg_if.index] <= '0;
      end
      // shared read-ahead for the table sweeps
      if (state_r == ST_SCAN1 || state_r == ST_SHIFT || state_r == ST_SCANA) begin
        p_v_r   <= issue;
        p_idx_r <= idx_r;
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r  <= in_if.command;
            pid_r  <= in_if.pid;
            res_r  <= in_if.resource;
            idx_r  <= '0;
            p_v_r  <= 1'b0;
            keep_r <= '0;
            nf_r   <= '0;
            fi_r   <= '0;
            woken_r <= '0;
            last_r <= 1'b1;
            priority if (in_if.command == csrm_pkg::CMD_RELEASE_ALL) begin
              state_r <= ST_SCANA;
            end else if (!res_ok) begin
              state_r <= ST_IDLE;
            end else if (in_if.command == csrm_pkg::CMD_RELEASE) begin
              state_r <= ST_SCAN1;
            end else if (in_if.command == csrm_pkg::CMD_ACQUIRE) begin
              state_r <= ST_EMIT;
              if (cnt_r[in_if.resource] >= 1) begin
                if (table_full) begin
                  kind_r <= csrm_pkg::KIND_TABLE_FULL;
                end else begin
                  kind_r <= csrm_pkg::KIND_GRANTED;
                  cnt_r[in_if.resource] <= cnt_r[in_if.resource] - csrm_pkg::counter_t'(1);
                  used_r <= used_r + 1'b1;
                end
              end else if (32'(wcnt_r[in_if.resource]) >= csrm_pkg::WAIT_DEPTH) begin
                kind_r <= csrm_pkg::KIND_QUEUE_FULL;
              end else begin
                kind_r <= csrm_pkg::KIND_BLOCKED;
                cnt_r[in_if.resource]  <= cnt_r[in_if.resource] - csrm_pkg::counter_t'(1);
                tail_r[in_if.resource] <= wrap_inc(tail_r[in_if.resource]);
                wcnt_r[in_if.resource] <= wcnt_r[in_if.resource] + 1'b1;
              end
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SCAN1: begin
          if (p_v_r && g_match) begin
            state_r <= ST_SHIFT;
          end else if (scan_done) begin
            if (cnt_r[res_r] < 0 && wcnt_r[res_r] != '0 && table_full) begin
              kind_r  <= csrm_pkg::KIND_TABLE_FULL;
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_INC;
            end
          end
        end
        ST_SHIFT: begin
          if (scan_done) begin
            used_r  <= used_r - 1'b1;
            state_r <= ST_INC;
          end
        end
        ST_SCANA: begin
          if (p_v_r) begin
            if (g_rdata_r.pid == pid_r) begin
              freed_r[nf_r[csrm_pkg::GADDR_W-1:0]] <= g_rdata_r.res;
              nf_r <= nf_r + 1'b1;
            end else begin
              keep_r <= keep_r + 1'b1;
            end
          end else if (scan_done) begin
            used_r <= keep_r;
            if (nf_r == '0) begin
              kind_r  <= csrm_pkg::KIND_DONE;
              res_r   <= '0;
              state_r <= ST_EMIT;
            end else begin
              last_r  <= 1'b0;
              state_r <= ST_INC;
            end
          end
        end
        ST_INC: begin
          res_r   <= inc_res;
          woken_r <= '0;
          if (cnt_r[inc_res] < 0 && wcnt_r[inc_res] != '0) begin
            state_r <= ST_WAKE;
          end else begin
            cnt_r[inc_res] <= sat_inc(cnt_r[inc_res]);
            kind_r  <= csrm_pkg::KIND_FREED;
            state_r <= ST_EMIT;
          end
        end
        ST_WAKE: begin
          if (!table_full) begin
            used_r <= used_r + 1'b1;
          end
          head_r[res_r] <= wrap_inc(head_r[res_r]);
          wcnt_r[res_r] <= wcnt_r[res_r] - 1'b1;
          cnt_r[res_r]  <= sat_inc(cnt_r[res_r]);
          kind_r  <= csrm_pkg::KIND_WOKE;
          woken_r <= f_rdata_r;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_woken_r <= woken_r;
            out_res_r   <= res_r;
            out_last_r  <= last_r;
            priority if (last_r) begin
              state_r <= ST_IDLE;
            end else if (fi_r + 1'b1 < nf_r) begin
              fi_r    <= fi_r + 1'b1;
              state_r <= ST_INC;
            end else begin
              // all freed grants reported: close with done
              kind_r  <= csrm_pkg::KIND_DONE;
              woken_r <= '0;
              res_r   <= '0;
              last_r  <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/csrm_checker.sv =====
// ----------------------------------------------------------------------------
// csrm_checker
// Port-level checks on the result channel of the semaphore manager.
// ----------------------------------------------------------------------------
`include "counting_semaphore_resource_manager_top_assert.svh"

module csrm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [csrm_pkg::KIND_W-1:0] out_kind,
  input logic [csrm_pkg::PID_W-1:0]  out_woken_pid,
  input logic [csrm_pkg::RES_W-1:0]  out_resource_out,
  input logic                        out_last
);

  `CSRM_ASSERT_ALWAYS_NEXT(a_reset_clears, clk, !rst_n, !out_valid)
  `CSRM_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CSRM_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && out_kind == csrm_pkg::KIND_DONE, out_last && out_resource_out == '0)
  `CSRM_ASSERT_NOW(a_mid_freed, clk, rst_n, out_valid && !out_last, out_kind == csrm_pkg::KIND_FREED || out_kind == csrm_pkg::KIND_WOKE)
  `CSRM_ASSERT_NOW(a_woken_zero, clk, rst_n, out_valid && out_kind != csrm_pkg::KIND_WOKE, out_woken_pid == '0)

endmodule

bind counting_semaphore_resource_manager_top csrm_checker u_csrm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_kind         (out_if.kind),
  .out_woken_pid    (out_if.woken_pid),
  .out_resource_out (out_if.resource_out),
  .out_last         (out_if.last)
);
